// ----- design/slrt_pkg.sv -----
// Shared types, widths and codes for the linear-ramp stepper step timer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package slrt_pkg;

    localparam int DELAY_W    = 22;
    localparam int COUNT_W    = 32;
    localparam int POS_W      = 32;
    localparam int CLK_W      = 8;
    localparam int CODE_W     = 3;
    localparam int TICKS_W    = 16;
    localparam int CYC_W      = CLK_W + DELAY_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 112;

    // divider operands: delay times (4n+1) over 4n-1 for a ramp-down step, twice the delay over 4n+1 otherwise
    localparam int DIV_NUM_W = DELAY_W + DELAY_W + 2;
    localparam int DIV_DEN_W = DELAY_W + 2;

    localparam int TIMER_RES_DEFAULT = 65536;

    localparam logic [DELAY_W-1:0] START_DELAY_RST = 22'd1000;
    localparam logic [DELAY_W-1:0] THRESHOLD_RST   = 22'h3FFFFF;
    localparam logic [CLK_W-1:0]   CLOCK_MHZ_RST   = 8'd16;
    localparam logic               INVERT_RST      = 1'b0;
    localparam logic [DELAY_W-1:0] RAMP_MAX        = 22'h3FFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_DELAY = 2'd0,
        CFG_THRESHOLD   = 2'd1,
        CFG_CLOCK_MHZ   = 2'd2,
        CFG_INVERT      = 2'd3
    } cfg_reg_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [CODE_W-1:0] {
        PRE_DIV1    = 3'd0,
        PRE_DIV8    = 3'd1,
        PRE_DIV64   = 3'd2,
        PRE_DIV256  = 3'd3,
        PRE_DIV1024 = 3'd4
    } prescale_t;

    typedef enum logic [2:0] {
        KIND_START = 3'd0,
        KIND_HOLD  = 3'd1,
        KIND_HALT  = 3'd2,
        KIND_UP    = 3'd3,
        KIND_DOWN  = 3'd4
    } kind_t;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic               operation;
        logic               direction;
        logic [DELAY_W-1:0] target_delay;
        logic [COUNT_W-1:0] target_count;
        logic               run;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0]  prescale_code;
        logic [TICKS_W-1:0] compare_ticks;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] step_count;
        logic [DELAY_W-1:0] current_delay;
        logic               at_target;
        logic               done_res;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic apply;
        logic div_start;
        logic update;
        logic tmul;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic needs_div;
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

// ----- design/slrt_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on slrt_pkg for default operand widths.
`default_nettype none

module slrt_div #(
    parameter int NumW = slrt_pkg::DIV_NUM_W,
    parameter int DenW = slrt_pkg::DIV_DEN_W
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [NumW-1:0] num,
    input  wire logic [DenW-1:0] den,
    output logic                 done,
    output logic [NumW-1:0]      quotient
);

    localparam int CntW = $clog2(NumW);

    logic [CntW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DenW-1:0] rem_reg;
    logic [DenW-1:0] rem_next;
    logic [DenW-1:0] den_reg;
    logic [NumW-1:0] quo_reg;
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic            ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NumW-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[DenW-1:0] : trial[DenW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CntW'(NumW - 1);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // quotient bits shift in as the dividend shifts out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NumW-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- design/slrt_dp.sv -----
// Datapath: configuration, move state, ramp arithmetic and timer setting.
// Depends on slrt_pkg and slrt_div; driven by commands from slrt_ctrl.
`default_nettype none

module slrt_dp #(
    parameter int TimerResolution = slrt_pkg::TIMER_RES_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire slrt_pkg::cfg_wr_t   cfg_wr,
    input  wire slrt_pkg::in_item_t  in_item,
    input  wire slrt_pkg::cmd_t      cmd,
    output slrt_pkg::status_t        status,
    output slrt_pkg::out_item_t      out_item
);

    localparam int DW = slrt_pkg::DELAY_W;
    localparam int CW = slrt_pkg::COUNT_W;
    localparam logic [31:0] Lim1    = 32'(TimerResolution);
    localparam logic [31:0] Lim8    = 32'(TimerResolution * 8);
    localparam logic [31:0] Lim64   = 32'(TimerResolution * 64);
    localparam logic [31:0] Lim256  = 32'(TimerResolution * 256);
    localparam logic [31:0] Lim1024 = 32'(TimerResolution * 1024);
    localparam logic [slrt_pkg::TICKS_W-1:0] TicksMax =
        slrt_pkg::TICKS_W'(TimerResolution - 1);

    // configuration
    logic [DW-1:0]              start_delay_reg;
    logic [DW-1:0]              threshold_reg;
    logic [slrt_pkg::CLK_W-1:0] clock_mhz_reg;
    logic                       invert_reg;

    // move state
    slrt_pkg::in_item_t         in_reg;
    logic [slrt_pkg::POS_W-1:0] position_reg, position_next;
    logic [CW-1:0]              steps_reg, steps_next;
    logic [DW-1:0]              delay_reg, delay_next;
    logic [DW-1:0]              goal_delay_reg, goal_delay_next;
    logic [DW-1:0]              ramp_reg, ramp_next;
    logic [CW-1:0]              goal_count_reg, goal_count_next;
    logic                       running_reg, running_next;
    logic                       reached_reg, reached_next;
    logic                       stopped_reg, stopped_next;
    slrt_pkg::kind_t            kind_reg, kind_next;
    logic [slrt_pkg::CYC_W-1:0] cyc_reg;
    slrt_pkg::out_item_t        out_reg, out_next;

    // arithmetic
    logic [slrt_pkg::DIV_NUM_W-1:0] div_num;
    logic [slrt_pkg::DIV_DEN_W-1:0] div_den;
    logic [slrt_pkg::DIV_DEN_W-1:0] den_up;
    logic [slrt_pkg::DIV_DEN_W-1:0] den_down;
    logic [slrt_pkg::DIV_NUM_W-1:0] quotient;
    logic                           div_done;
    logic [DW-1:0]                  delay_dec;
    logic                           instant;
    logic [31:0]                    cyc32;
    logic [slrt_pkg::CODE_W-1:0]    code;
    logic [slrt_pkg::TICKS_W-1:0]   ticks;
    logic [CW:0]                    steps_plus_ramp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delay_reg <= slrt_pkg::START_DELAY_RST;
            threshold_reg   <= slrt_pkg::THRESHOLD_RST;
            clock_mhz_reg   <= slrt_pkg::CLOCK_MHZ_RST;
            invert_reg      <= slrt_pkg::INVERT_RST;
        end
        else if (cfg_wr.en)
        begin
            case (slrt_pkg::cfg_reg_t'(cfg_wr.index))
                slrt_pkg::CFG_START_DELAY: start_delay_reg <= cfg_wr.data[DW-1:0];
                slrt_pkg::CFG_THRESHOLD:   threshold_reg   <= cfg_wr.data[DW-1:0];
                slrt_pkg::CFG_CLOCK_MHZ:   clock_mhz_reg   <= cfg_wr.data[slrt_pkg::CLK_W-1:0];
                slrt_pkg::CFG_INVERT:      invert_reg      <= cfg_wr.data[0];
                default: ;
            endcase
        end
    end

    assign instant = (goal_delay_reg >= threshold_reg) && (delay_reg >= threshold_reg);
    assign status.needs_div = (in_reg.operation == slrt_pkg::OP_STEP) && !instant
                              && (delay_reg != goal_delay_reg);
    assign status.div_done  = div_done;

    // divider operands use the ramp count already updated by the apply step
    assign den_up   = {ramp_reg, 2'b01};
    assign den_down = {ramp_reg - 1'b1, 2'b11};

    always_comb
    begin
        if (kind_reg == slrt_pkg::KIND_DOWN)
        begin
            div_num = slrt_pkg::DIV_NUM_W'(delay_reg) * slrt_pkg::DIV_NUM_W'(den_up);
            div_den = den_down;
        end
        else
        begin
            div_num = slrt_pkg::DIV_NUM_W'({delay_reg, 1'b0});
            div_den = den_up;
        end
    end

    slrt_div #(
        .NumW (slrt_pkg::DIV_NUM_W),
        .DenW (slrt_pkg::DIV_DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (quotient)
    );

    assign delay_dec = delay_reg - quotient[DW-1:0];

    // prescaler selection from the registered cycle count
    always_comb
    begin
        cyc32 = 32'(cyc_reg);
        if (cyc32 < Lim1)
        begin
            code  = slrt_pkg::PRE_DIV1;
            ticks = cyc32[15:0];
        end
        else if (cyc32 < Lim8)
        begin
            code  = slrt_pkg::PRE_DIV8;
            ticks = cyc32[18:3];
        end
        else if (cyc32 < Lim64)
        begin
            code  = slrt_pkg::PRE_DIV64;
            ticks = cyc32[21:6];
        end
        else if (cyc32 < Lim256)
        begin
            code  = slrt_pkg::PRE_DIV256;
            ticks = cyc32[23:8];
        end
        else if (cyc32 < Lim1024)
        begin
            code  = slrt_pkg::PRE_DIV1024;
            ticks = cyc32[25:10];
        end
        else
        begin
            code  = slrt_pkg::PRE_DIV1024;
            ticks = TicksMax;
        end
    end

    assign steps_plus_ramp = {1'b0, steps_reg} + (CW+1)'(ramp_reg);

    always_comb
    begin
        position_next   = position_reg;
        steps_next      = steps_reg;
        delay_next      = delay_reg;
        goal_delay_next = goal_delay_reg;
        ramp_next       = ramp_reg;
        goal_count_next = goal_count_reg;
        running_next    = running_reg;
        reached_next    = reached_reg;
        stopped_next    = stopped_reg;
        kind_next       = kind_reg;
        out_next        = out_reg;

        if (cmd.apply)
        begin
            if (in_reg.operation == slrt_pkg::OP_START)
            begin
                goal_delay_next = in_reg.target_delay;
                goal_count_next = in_reg.target_count;
                running_next    = in_reg.run;
                steps_next      = '0;
                ramp_next       = '0;
                delay_next      = start_delay_reg;
                reached_next    = 1'b0;
                stopped_next    = 1'b0;
                kind_next       = slrt_pkg::KIND_START;
            end
            else
            begin
                position_next = (in_reg.direction != invert_reg) ? position_reg + 1'b1
                                                                 : position_reg - 1'b1;
                steps_next    = steps_reg + 1'b1;
                kind_next     = slrt_pkg::KIND_HOLD;
                if (instant)
                begin
                    if (!running_reg)
                    begin
                        ramp_next    = '0;
                        delay_next   = start_delay_reg;
                        reached_next = 1'b1;
                        stopped_next = 1'b1;
                        kind_next    = slrt_pkg::KIND_HALT;
                    end
                    else if (delay_reg != goal_delay_reg)
                    begin
                        ramp_next    = DW'(1);
                        delay_next   = goal_delay_reg;
                        reached_next = 1'b1;
                    end
                end
                else if (delay_reg > goal_delay_reg)
                begin
                    ramp_next = (ramp_reg < slrt_pkg::RAMP_MAX) ? ramp_reg + 1'b1 : ramp_reg;
                    kind_next = slrt_pkg::KIND_UP;
                end
                else if (delay_reg < goal_delay_reg)
                begin
                    ramp_next = (ramp_reg > DW'(1)) ? ramp_reg - 1'b1 : DW'(1);
                    kind_next = slrt_pkg::KIND_DOWN;
                end
            end
        end

        if (cmd.update)
        begin
            if (kind_reg == slrt_pkg::KIND_UP)
            begin
                if (delay_dec <= goal_delay_reg)
                begin
                    delay_next   = goal_delay_reg;
                    reached_next = 1'b1;
                end
                else
                begin
                    delay_next = delay_dec;
                end
            end
            else
            begin
                if (quotient >= slrt_pkg::DIV_NUM_W'(goal_delay_reg))
                begin
                    delay_next   = goal_delay_reg;
                    reached_next = 1'b1;
                end
                else
                begin
                    delay_next = quotient[DW-1:0];
                end
            end
        end

        if (cmd.finish)
        begin
            // switch to ramp-down once the steps left match the ramp length
            if (kind_reg != slrt_pkg::KIND_START && kind_reg != slrt_pkg::KIND_HALT
                && running_reg && steps_plus_ramp >= (CW+1)'(goal_count_reg))
            begin
                running_next    = 1'b0;
                goal_delay_next = start_delay_reg;
                reached_next    = 1'b0;
            end
            out_next.prescale_code = (kind_reg == slrt_pkg::KIND_HALT) ? '0 : code;
            out_next.compare_ticks = (kind_reg == slrt_pkg::KIND_HALT) ? '0 : ticks;
            out_next.position      = position_reg;
            out_next.step_count    = steps_reg;
            out_next.current_delay = delay_reg;
            out_next.at_target     = reached_next;
            out_next.done_res      = stopped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            steps_reg      <= '0;
            delay_reg      <= slrt_pkg::START_DELAY_RST;
            goal_delay_reg <= slrt_pkg::START_DELAY_RST;
            ramp_reg       <= '0;
            goal_count_reg <= '0;
            running_reg    <= 1'b0;
            reached_reg    <= 1'b0;
            stopped_reg    <= 1'b1;
            kind_reg       <= slrt_pkg::KIND_START;
        end
        else
        begin
            position_reg   <= position_next;
            steps_reg      <= steps_next;
            delay_reg      <= delay_next;
            goal_delay_reg <= goal_delay_next;
            ramp_reg       <= ramp_next;
            goal_count_reg <= goal_count_next;
            running_reg    <= running_next;
            reached_reg    <= reached_next;
            stopped_reg    <= stopped_next;
            kind_reg       <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_item;
        end
        if (cmd.tmul)
        begin
            cyc_reg <= slrt_pkg::CYC_W'(clock_mhz_reg) * slrt_pkg::CYC_W'(delay_reg);
        end
        out_reg <= out_next;
    end

    assign out_item = out_reg;

endmodule

`default_nettype wire

// ----- design/slrt_ctrl.sv -----
// Controller: sequences load, ramp update, divider and timer setup per item.
// Depends on slrt_pkg; commands slrt_dp through cmd_t and reads status_t.
`default_nettype none

module slrt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire slrt_pkg::status_t status,
    output slrt_pkg::cmd_t         cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_APPLY  = 7'b0000010,
        ST_PREP   = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_UPDATE = 7'b0010000,
        ST_TMUL   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = status.needs_div ? ST_PREP : ST_TMUL;
            end
            ST_PREP:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_TMUL;
            end
            ST_TMUL:
            begin
                cmd.tmul   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ----- design/stepper_linear_ramp_step_timer_unit.sv -----
// Linear-ramp stepper step timer, top level. Depends on slrt_pkg, slrt_ctrl, slrt_dp.
// Each item runs apply, then for a ramp step the divider start, serial divide and update,
//   then timer multiply and finish; start, instant and steady steps skip the divider.
// One item at a time: a new beat is taken only once the previous item has finished;
//   a waiting result does not block the next input beat.
// Reset (rst_n, asynchronous, active low) restores default configuration and idle state.
`default_nettype none

module stepper_linear_ramp_step_timer_unit #(
    parameter int TimerResolution = slrt_pkg::TIMER_RES_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // direction, target_delay, target_count, run
    input  wire logic [slrt_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation
    input  wire logic [0:0]                      s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // prescale_code, compare_ticks, position, step_count, current_delay,
    // at_target, done_res, then zero padding
    output logic [slrt_pkg::M_TDATA_W-1:0]       m_tdata,
    // configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [slrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [slrt_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int OutBits = $bits(slrt_pkg::out_item_t);

    slrt_pkg::cfg_wr_t   cfg_wr;
    slrt_pkg::in_item_t  in_item;
    slrt_pkg::out_item_t out_item;
    slrt_pkg::cmd_t      cmd;
    slrt_pkg::status_t   status;

    assign cfg_wr.en    = cfg_wr_en;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    // unpack the input beat: operation rides in tuser, the rest in tdata
    assign in_item.operation    = s_tuser[0];
    assign in_item.direction    = s_tdata[0];
    assign in_item.target_delay = s_tdata[22:1];
    assign in_item.target_count = s_tdata[54:23];
    assign in_item.run          = s_tdata[55];

    // pack the result: first field in the lowest bits
    assign m_tdata[2:0]     = out_item.prescale_code;
    assign m_tdata[18:3]    = out_item.compare_ticks;
    assign m_tdata[50:19]   = out_item.position;
    assign m_tdata[82:51]   = out_item.step_count;
    assign m_tdata[104:83]  = out_item.current_delay;
    assign m_tdata[105]     = out_item.at_target;
    assign m_tdata[106]     = out_item.done_res;
    assign m_tdata[slrt_pkg::M_TDATA_W-1:OutBits] = '0;

    // controller: walks each item through apply, then divide and update for ramp steps, then timer, finish
    slrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: move state, ramp arithmetic and the result register
    slrt_dp #(
        .TimerResolution (TimerResolution)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_item)
    );

`ifndef ASSERT_OFF
    // one item at a time: an accepted beat closes the input until its result is built
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // prescaler code stays within the divider set
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= 3'd4))
        else $error("prescale code out of range");

    // a fresh result only comes out of a finished item, never straight from idle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without an item being processed");
`endif

endmodule

`default_nettype wire
